// ----- sv/sva_pkg.sv -----
// Shared types and constants for the voice allocator
// No dependencies; every other file imports this package

package sva_pkg;

  // fixed field widths of the item words
  localparam int unsigned OPC_W     = 2;
  localparam int unsigned TRACK_W   = 4;
  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned VIDX_W    = 3;
  localparam int unsigned CNT_W     = 4;
  // wide enough to hold any voice or track index in the supported range
  localparam int unsigned IDX_EXT_W = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef enum logic [OPC_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_REL_DONE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_ON   = 2'd1,
    MODE_REL  = 2'd2
  } mode_e;

  // one voice table entry
  typedef struct packed {
    mode_e               mode;
    logic [FREQ_W-1:0]   freq;
    logic [TRACK_W-1:0]  owner;
  } voice_t;

  // read / write strobes toward a memory
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [TRACK_W-1:0] track;
    logic [FREQ_W-1:0]  note_freq;
    logic [VIDX_W-1:0]  voice_index;
  } in_word_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  assigned_voice;
    logic               stole;
    logic [TRACK_W-1:0] stolen_track;
    logic [CNT_W-1:0]   track_voices;
  } out_word_t;

endpackage

// ----- sv/sva_if.sv -----
// Valid/ready channel interfaces for event and result words
// Depends on sva_pkg for the word types

interface sva_in_if import sva_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface sva_out_if import sva_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ----- sv/sva_voice_mem.sv -----
// Voice table: single-port synchronous memory with a registered read
// Per-entry written bits make never-written entries read as free; uses sva_pkg

module sva_voice_mem import sva_pkg::*; #(
  parameter int unsigned VOICES = 8,
  localparam int unsigned VW    = $clog2(VOICES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mem_ctl_t      ctl_i,
  input  logic [VW-1:0] addr_i,
  input  voice_t        wdata_i,
  output voice_t        rdata_o
);

  voice_t              mem_q [VOICES];
  logic [VOICES-1:0]   written_q;
  voice_t              rdata_q;
  logic                rwritten_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // written bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        written_q[addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rwritten_q <= written_q[addr_i];
      end
    end
  end

  // an entry never written reads as a free voice
  always_comb begin
    rdata_o = rdata_q;
    if (!rwritten_q) begin
      rdata_o.mode = MODE_FREE;
    end
  end

endmodule

// ----- sv/sva_count_mem.sv -----
// Per-track voice count memory, single port, registered read
// Per-entry written bits make untouched tracks read as zero; uses sva_pkg

module sva_count_mem import sva_pkg::*; #(
  parameter int unsigned TRACKS = 16,
  localparam int unsigned TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_ctl_t         ctl_i,
  input  logic [TW-1:0]    addr_i,
  input  logic [CNT_W-1:0] wdata_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0]  mem_q [TRACKS];
  logic [TRACKS-1:0] written_q;
  logic [CNT_W-1:0]  rdata_q;
  logic              rwritten_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // written bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        written_q[addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rwritten_q <= written_q[addr_i];
      end
    end
  end

  assign rdata_o = rwritten_q ? rdata_q : '0;

endmodule

// ----- sv/sva_ctrl.sv -----
// Event sequencer: voice scan, steal choice and count read-modify-write
// Drives both memories and the channels; uses sva_pkg and sva_if

module sva_ctrl import sva_pkg::*; #(
  parameter int unsigned VOICES = 8,
  parameter int unsigned TRACKS = 16,
  localparam int unsigned VW    = $clog2(VOICES),
  localparam int unsigned TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sva_in_if.sink           in_i,
  sva_out_if.source        out_o,
  output mem_ctl_t         vctl_o,
  output logic [VW-1:0]    vaddr_o,
  output voice_t           vwdata_o,
  input  voice_t           vrdata_i,
  output mem_ctl_t         cctl_o,
  output logic [TW-1:0]    caddr_o,
  output logic [CNT_W-1:0] cwdata_o,
  input  logic [CNT_W-1:0] crdata_i
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SCAN   = 11'b000_0000_0010,
    S_DRAIN  = 11'b000_0000_0100,
    S_PICK   = 11'b000_0000_1000,
    S_VRD    = 11'b000_0001_0000,
    S_VCHK   = 11'b000_0010_0000,
    S_DEC    = 11'b000_0100_0000,
    S_INC_RD = 11'b000_1000_0000,
    S_INC    = 11'b001_0000_0000,
    S_GET    = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [OPC_W-1:0]   op_q, op_d;
  logic [TRACK_W-1:0] trk_q, trk_d;
  logic [FREQ_W-1:0]  freq_q, freq_d;
  logic [VIDX_W-1:0]  vi_q, vi_d;
  out_word_t          res_q, res_d;
  logic [TW-1:0]      cidx_q, cidx_d;

  logic [VW-1:0]      scan_idx_q, scan_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [VW-1:0]      rd_idx_q, rd_idx_d;

  logic               free_found_q, free_found_d;
  logic [VW-1:0]      free_idx_q, free_idx_d;
  logic               rel_found_q, rel_found_d;
  logic [VW-1:0]      rel_idx_q, rel_idx_d;
  logic [FREQ_W-1:0]  rel_freq_q, rel_freq_d;
  logic [TRACK_W-1:0] rel_own_q, rel_own_d;
  logic [VW-1:0]      low_idx_q, low_idx_d;
  logic [FREQ_W-1:0]  low_freq_q, low_freq_d;
  logic [TRACK_W-1:0] low_own_q, low_own_d;

  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic               accept;
  logic [VW-1:0]      vi_idx;
  logic [VW-1:0]      pick;
  logic [TRACK_W-1:0] old_own;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W-1:0]   cnt_inc;

  function automatic logic trk_ok(logic [TRACK_W-1:0] t);
    return IDX_EXT_W'(t) < IDX_EXT_W'(TRACKS);
  endfunction

  function automatic logic [TW-1:0] trk_idx(logic [TRACK_W-1:0] t);
    logic [IDX_EXT_W-1:0] e;
    e = IDX_EXT_W'(t);
    return e[TW-1:0];
  endfunction

  // handshake and fixed decodes
  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  always_comb begin
    logic [IDX_EXT_W-1:0] vi_ext;
    vi_ext = IDX_EXT_W'(vi_q);
    vi_idx = vi_ext[VW-1:0];
  end

  // voice choice: first free voice, else lowest-frequency releasing voice, else lowest frequency overall
  assign pick    = free_found_q ? free_idx_q : (rel_found_q ? rel_idx_q : low_idx_q);
  assign old_own = rel_found_q ? rel_own_q : low_own_q;

  // saturating count arithmetic
  assign cnt_dec = (crdata_i != '0) ? crdata_i - CNT_W'(1) : '0;
  assign cnt_inc = (crdata_i != CNT_MAX) ? crdata_i + CNT_W'(1) : crdata_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    trk_d        = trk_q;
    freq_d       = freq_q;
    vi_d         = vi_q;
    res_d        = res_q;
    cidx_d       = cidx_q;
    scan_idx_d   = scan_idx_q;
    rd_vld_d     = (state_q == S_SCAN);
    rd_idx_d     = scan_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    rel_found_d  = rel_found_q;
    rel_idx_d    = rel_idx_q;
    rel_freq_d   = rel_freq_q;
    rel_own_d    = rel_own_q;
    low_idx_d    = low_idx_q;
    low_freq_d   = low_freq_q;
    low_own_d    = low_own_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_word_d   = out_word_q;
    vctl_o       = '0;
    vaddr_o      = vi_idx;
    vwdata_o     = vrdata_i;
    cctl_o       = '0;
    caddr_o      = cidx_q;
    cwdata_o     = crdata_i;

    // fold one scanned entry into the candidates
    if (rd_vld_q) begin
      if (!free_found_q && vrdata_i.mode == MODE_FREE) begin
        free_found_d = 1'b1;
        free_idx_d   = rd_idx_q;
      end
      if (rd_idx_q == '0 || vrdata_i.freq < low_freq_q) begin
        low_idx_d  = rd_idx_q;
        low_freq_d = vrdata_i.freq;
        low_own_d  = vrdata_i.owner;
      end
      if (vrdata_i.mode == MODE_REL && (!rel_found_q || vrdata_i.freq < rel_freq_q)) begin
        rel_found_d = 1'b1;
        rel_idx_d   = rd_idx_q;
        rel_freq_d  = vrdata_i.freq;
        rel_own_d   = vrdata_i.owner;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = in_i.word.opcode;
          trk_d        = in_i.word.track;
          freq_d       = in_i.word.note_freq;
          vi_d         = in_i.word.voice_index;
          res_d        = '0;
          scan_idx_d   = '0;
          free_found_d = 1'b0;
          rel_found_d  = 1'b0;
          unique case (in_i.word.opcode)
            OP_NOTE_ON: begin
              state_d = trk_ok(in_i.word.track) ? S_SCAN : S_FIN;
            end
            OP_NOTE_OFF, OP_REL_DONE: begin
              res_d.assigned_voice = in_i.word.voice_index;
              state_d = (IDX_EXT_W'(in_i.word.voice_index) < IDX_EXT_W'(VOICES)) ?
                        S_VRD : S_FIN;
            end
            default: begin
              res_d.assigned_voice = in_i.word.voice_index;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        vctl_o.rd  = 1'b1;
        vaddr_o    = scan_idx_q;
        scan_idx_d = scan_idx_q + VW'(1);
        if (scan_idx_q == VW'(VOICES - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        // bind the chosen voice, then start the count updates
        vctl_o.wr            = 1'b1;
        vaddr_o              = pick;
        vwdata_o             = '{mode: MODE_ON, freq: freq_q, owner: trk_q};
        res_d.assigned_voice = VIDX_W'(pick);
        res_d.stole          = !free_found_q;
        res_d.stolen_track   = free_found_q ? '0 : old_own;
        cctl_o.rd            = 1'b1;
        if (!free_found_q && trk_ok(old_own)) begin
          caddr_o = trk_idx(old_own);
          cidx_d  = trk_idx(old_own);
          state_d = S_DEC;
        end else begin
          caddr_o = trk_idx(trk_q);
          cidx_d  = trk_idx(trk_q);
          state_d = S_INC;
        end
      end
      S_VRD: begin
        vctl_o.rd = 1'b1;
        vaddr_o   = vi_idx;
        state_d   = S_VCHK;
      end
      S_VCHK: begin
        state_d = S_FIN;
        caddr_o = trk_idx(vrdata_i.owner);
        cidx_d  = trk_idx(vrdata_i.owner);
        if (op_q == OP_NOTE_OFF) begin
          if (vrdata_i.mode == MODE_ON) begin
            vctl_o.wr     = 1'b1;
            vwdata_o.mode = MODE_REL;
            if (trk_ok(vrdata_i.owner)) begin
              cctl_o.rd = 1'b1;
              state_d   = S_GET;
            end
          end
        end else if (vrdata_i.mode != MODE_FREE) begin
          vctl_o.wr     = 1'b1;
          vwdata_o.mode = MODE_FREE;
          if (trk_ok(vrdata_i.owner)) begin
            cctl_o.rd = 1'b1;
            state_d   = S_DEC;
          end
        end
      end
      S_DEC: begin
        cctl_o.wr = 1'b1;
        cwdata_o  = cnt_dec;
        if (op_q == OP_NOTE_ON) begin
          state_d = S_INC_RD;
        end else begin
          res_d.track_voices = cnt_dec;
          state_d = S_FIN;
        end
      end
      S_INC_RD: begin
        // read after the decrement has landed, same track included
        cctl_o.rd = 1'b1;
        caddr_o   = trk_idx(trk_q);
        cidx_d    = trk_idx(trk_q);
        state_d   = S_INC;
      end
      S_INC: begin
        cctl_o.wr          = 1'b1;
        cwdata_o           = cnt_inc;
        res_d.track_voices = cnt_inc;
        state_d            = S_FIN;
      end
      S_GET: begin
        res_d.track_voices = crdata_i;
        state_d            = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // event fields, scan candidates and result word
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    trk_q        <= trk_d;
    freq_q       <= freq_d;
    vi_q         <= vi_d;
    res_q        <= res_d;
    cidx_q       <= cidx_d;
    scan_idx_q   <= scan_idx_d;
    rd_idx_q     <= rd_idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    rel_found_q  <= rel_found_d;
    rel_idx_q    <= rel_idx_d;
    rel_freq_q   <= rel_freq_d;
    rel_own_q    <= rel_own_d;
    low_idx_q    <= low_idx_d;
    low_freq_q   <= low_freq_d;
    low_own_q    <= low_own_d;
    out_word_q   <= out_word_d;
  end

  // checks
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result word raised outside the finish step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted event did not start work");

  a_vmem_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vctl_o.rd && vctl_o.wr))
    else $error("voice table read and written in one cycle");

  a_steal_only_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && res_q.stole) |-> op_q == OP_NOTE_ON)
    else $error("steal reported for an event other than note on");

  a_count_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC || state_q == S_INC || state_q == S_GET) |->
      $past(cctl_o.rd))
    else $error("count update without a preceding read");

endmodule

// ----- sv/synth_voice_allocator_top.sv -----
// Note on: voice scan at one entry per cycle, then the pick, then a decrement of
//   a stolen voice's count where needed, then the increment of the event's track
// Note off / release finished: read, check, count step; unused opcode or bad index: no steps
// One event in flight; the next is accepted the cycle after its result is
//   registered, while that result may still wait on the output
// Reset (async, active low) clears written bits: all voices free, counts zero

module synth_voice_allocator_top import sva_pkg::*; #(
  parameter int unsigned VOICES = 8,
  parameter int unsigned TRACKS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sva_in_if.sink    in_i,
  sva_out_if.source out_o
);

  localparam int unsigned VW = $clog2(VOICES);
  localparam int unsigned TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  mem_ctl_t         vctl;
  logic [VW-1:0]    vaddr;
  voice_t           vwdata;
  voice_t           vrdata;
  mem_ctl_t         cctl;
  logic [TW-1:0]    caddr;
  logic [CNT_W-1:0] cwdata;
  logic [CNT_W-1:0] crdata;

  // voice table
  sva_voice_mem #(
    .VOICES (VOICES)
  ) u_voice_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (vctl),
    .addr_i  (vaddr),
    .wdata_i (vwdata),
    .rdata_o (vrdata)
  );

  // per-track counts
  sva_count_mem #(
    .TRACKS (TRACKS)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cctl),
    .addr_i  (caddr),
    .wdata_i (cwdata),
    .rdata_o (crdata)
  );

  // event sequencer
  sva_ctrl #(
    .VOICES (VOICES),
    .TRACKS (TRACKS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .vctl_o   (vctl),
    .vaddr_o  (vaddr),
    .vwdata_o (vwdata),
    .vrdata_i (vrdata),
    .cctl_o   (cctl),
    .caddr_o  (caddr),
    .cwdata_o (cwdata),
    .crdata_i (crdata)
  );

endmodule
